// ===== hw/rtl/ipur_pkg.sv =====
// Shared types and constants for the indexed pixel unpack and remap block.
package ipur_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int MAX_WIDTH   = 1024;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [8:0]  PALETTE_RESET = 9'd256;
   localparam logic [10:0] WIDTH_RESET   = 11'd32;
   localparam logic [10:0] HEIGHT_RESET  = 11'd32;
   localparam logic [11:0] PITCH_RESET   = 12'd32;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_ENTRY = 2'd1;
   localparam logic [1:0] FUNC_PIXEL = 2'd2;

   localparam logic [1:0] CSR_PALETTE_ENTRIES = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT    = 2'd2;
   localparam logic [1:0] CSR_ROW_PITCH       = 2'd3;

   typedef enum logic [1:0] {
      JOB_CLEAR,
      JOB_WRITE,
      JOB_PIXELS
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [1:0]   bpp_code;
      logic [2:0]   last_k;
      logic         row_end;
      logic         last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== hw/rtl/indexed_pixel_unpack_remap.sv =====
// Top level of the indexed pixel unpack and remap block.
//
// Input stream (req_): tuser carries the function (begin image, palette entry,
// pixel byte), tdata the entry index, entry color and packed data byte.
// Result stream (rsp_): one remapped 8-bit pixel per transaction, tuser marks
// the last pixel of a row, tlast the last pixel of the image.
// csr_ writes palette entry count, image width, image height and row pitch;
// write only while the block is idle. csr_ready is always high.
// The front end takes one transaction per cycle, while the queue is not full,
// into a four-entry job queue. The back end reads the table once per pixel of
// a pixel byte (up to eight at 1 bpp, one at 8 bpp) through its single read
// port and takes a table write or begin as one job. A pixel byte passes the
// queue, the table read and stage 1 registers, then the output register.
// Reset restores the register defaults, empties the queue and pipeline and
// marks every table entry unloaded (reads as zero); a begin does the same for
// the table and row counters. When rsp_tready is low the output register
// holds, the pipeline and queue fill, and req_tready drops once it is full.
module indexed_pixel_unpack_remap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // entry_index, entry_color, data_byte
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel
   output logic        rsp_tuser,   // row_end
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import ipur_pkg::*;

   logic         push;
   job_type      push_job;
   logic         pop;
   job_type      head;
   q_status_type q_status;

   ipur_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   ipur_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   ipur_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_queue_status : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_last_on_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("image end flagged on a pixel that does not end a row");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job taken from an empty queue");

   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");
`endif

endmodule

// ===== hw/rtl/ipur_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ipur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ipur_front.sv =====
// Front end: configuration registers, input acceptance, row tracking, job creation.
module ipur_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_data,
   input  ipur_pkg::q_status_type q_status,
   output logic                  push,
   output ipur_pkg::job_type     push_job
);
   import ipur_pkg::*;

   logic [8:0]  pal_entries_ff;
   logic [10:0] img_width_ff;
   logic [10:0] img_height_ff;
   logic [11:0] row_pitch_ff;
   logic [11:0] byte_in_row_ff, byte_in_row_in;
   logic [10:0] row_count_ff, row_count_in;

   logic        accept;
   logic [7:0]  entry_index;
   logic [7:0]  entry_color;
   logic [7:0]  data_byte;
   logic [1:0]  bpp_code;
   logic [3:0]  ppb;
   logic [10:0] width_eff;
   logic [11:0] pitch_eff;
   logic [14:0] start;
   logic [14:0] rem;
   logic [3:0]  n_pix;
   logic        active;
   logic        covers;
   logic        final_row;

   assign csr_ready   = 1'b1;
   assign req_tready  = !q_status.full;
   assign accept      = req_tvalid && req_tready;
   assign entry_index = req_tdata[7:0];
   assign entry_color = req_tdata[15:8];
   assign data_byte   = req_tdata[23:16];

   always_comb begin
      if (pal_entries_ff > 9'd16) begin
         bpp_code = 2'd3;
      end else if (pal_entries_ff > 9'd4) begin
         bpp_code = 2'd2;
      end else if (pal_entries_ff > 9'd2) begin
         bpp_code = 2'd1;
      end else begin
         bpp_code = 2'd0;
      end
   end

   assign ppb       = 4'd8 >> bpp_code;
   assign width_eff = (13'(img_width_ff) > 13'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : img_width_ff;
   assign pitch_eff = (row_pitch_ff == 12'd0) ? 12'd1 : row_pitch_ff;
   assign start     = 15'(byte_in_row_ff) << (2'd3 - bpp_code);
   assign rem       = 15'(width_eff) - start;
   assign covers    = start < 15'(width_eff);
   assign n_pix     = (rem >= 15'(ppb)) ? ppb : rem[3:0];
   assign active    = row_count_ff < img_height_ff;
   assign final_row = (12'(row_count_ff) + 12'd1) == 12'(img_height_ff);

   always_comb begin
      byte_in_row_in = byte_in_row_ff;
      row_count_in   = row_count_ff;
      push           = 1'b0;
      push_job       = '0;
      push_job.byte_a   = entry_index;
      push_job.byte_b   = entry_color;
      push_job.bpp_code = bpp_code;
      push_job.last_k   = 3'(n_pix - 4'd1);
      push_job.row_end  = rem <= 15'(ppb);
      push_job.last     = (rem <= 15'(ppb)) && final_row;
      case (req_tuser)
         FUNC_BEGIN: begin
            push_job.kind  = JOB_CLEAR;
            push           = accept;
            byte_in_row_in = '0;
            row_count_in   = '0;
         end
         FUNC_ENTRY: begin
            push_job.kind = JOB_WRITE;
            push          = accept;
         end
         FUNC_PIXEL: begin
            push_job.kind   = JOB_PIXELS;
            push_job.byte_a = data_byte;
            push            = accept && active && covers;
            if (active) begin
               if ((13'(byte_in_row_ff) + 13'd1) >= 13'(pitch_eff)) begin
                  byte_in_row_in = '0;
                  row_count_in   = row_count_ff + 11'd1;
               end else begin
                  byte_in_row_in = byte_in_row_ff + 12'd1;
               end
            end
         end
         default: begin
            push_job.kind = JOB_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_entries_ff <= PALETTE_RESET;
         img_width_ff   <= WIDTH_RESET;
         img_height_ff  <= HEIGHT_RESET;
         row_pitch_ff   <= PITCH_RESET;
         byte_in_row_ff <= '0;
         row_count_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PALETTE_ENTRIES: pal_entries_ff <= csr_data[8:0];
               CSR_IMAGE_WIDTH:     img_width_ff   <= csr_data[10:0];
               CSR_IMAGE_HEIGHT:    img_height_ff  <= csr_data[10:0];
               CSR_ROW_PITCH:       row_pitch_ff   <= csr_data;
               default:             row_pitch_ff   <= row_pitch_ff;
            endcase
         end
         if (accept) begin
            byte_in_row_ff <= byte_in_row_in;
            row_count_ff   <= row_count_in;
         end
      end
   end

endmodule

// ===== hw/rtl/ipur_queue.sv =====
// Short job queue between the front end and the back end.
module ipur_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ipur_pkg::job_type      push_job,
   input  logic                   pop,
   output ipur_pkg::job_type      head,
   output ipur_pkg::q_status_type status
);
   import ipur_pkg::*;

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/ipur_back.sv =====
// Back end: remap table, per-pixel unpacking, lookup pipeline and output register.
module ipur_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ipur_pkg::job_type      head,
   input  ipur_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);
   import ipur_pkg::*;

   logic [TABLE_DEPTH-1:0] ent_valid_ff;
   logic [2:0]             k_ff;
   logic                   s1_valid_ff;
   logic                   s1_hit_ff;
   logic                   s1_row_end_ff;
   logic                   s1_last_ff;
   logic                   out_valid_ff;
   logic [7:0]             out_pixel_ff;
   logic                   out_row_end_ff;
   logic                   out_last_ff;

   logic                   has_job;
   logic                   out_adv;
   logic                   s1_adv;
   logic                   issue;
   logic                   last_pix;
   logic                   wr_en;
   logic                   wr_in_range;
   logic                   rd_in_range;
   logic [2:0]             sh;
   logic [7:0]             shifted;
   logic [7:0]             idx;
   logic [7:0]             ram_dout;

   assign has_job  = !q_status.empty;
   assign out_adv  = !out_valid_ff || rsp_tready;
   assign s1_adv   = !s1_valid_ff || out_adv;
   assign issue    = has_job && (head.kind == JOB_PIXELS) && s1_adv;
   assign last_pix = k_ff == head.last_k;
   assign wr_en    = has_job && (head.kind == JOB_WRITE);
   assign pop      = (has_job && (head.kind != JOB_PIXELS)) || (issue && last_pix);

   assign sh      = 3'({3'b000, k_ff} << head.bpp_code);
   assign shifted = head.byte_a << sh;

   always_comb begin
      case (head.bpp_code)
         2'd0:    idx = {7'b0, shifted[7]};
         2'd1:    idx = {6'b0, shifted[7:6]};
         2'd2:    idx = {4'b0, shifted[7:4]};
         default: idx = shifted;
      endcase
   end

   assign wr_in_range = 9'(head.byte_a) < 9'(TABLE_DEPTH);
   assign rd_in_range = 9'(idx) < 9'(TABLE_DEPTH);

   ipur_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en && wr_in_range),
      .wr_addr (head.byte_a[TABLE_AW-1:0]),
      .wr_data (head.byte_b),
      .rd_en   (issue),
      .rd_addr (idx[TABLE_AW-1:0]),
      .rd_data (ram_dout)
   );

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_hit_ff     <= rd_in_range && ent_valid_ff[idx[TABLE_AW-1:0]];
         s1_row_end_ff <= last_pix && head.row_end;
         s1_last_ff    <= last_pix && head.last;
      end
      if (s1_valid_ff && out_adv) begin
         out_pixel_ff   <= s1_hit_ff ? ram_dout : 8'd0;
         out_row_end_ff <= s1_row_end_ff;
         out_last_ff    <= s1_last_ff;
      end
      if (reset) begin
         ent_valid_ff <= '0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (has_job && (head.kind == JOB_CLEAR)) begin
            ent_valid_ff <= '0;
         end else if (wr_en && wr_in_range) begin
            ent_valid_ff[head.byte_a[TABLE_AW-1:0]] <= 1'b1;
         end
         if (issue) begin
            k_ff <= last_pix ? 3'd0 : k_ff + 3'd1;
         end
         if (s1_adv) begin
            s1_valid_ff <= issue;
         end
         if (out_adv) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = out_row_end_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the indexed pixel unpack and remap block.
`timescale 1ns / 100ps

module tb;
   import ipur_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         SETTLE      = 16;
   localparam int         ITEM_TARGET = 320;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       last;
   } pixel_exp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = FUNC_BEGIN;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PALETTE_ENTRIES;
   logic [11:0] csr_data = '0;

   logic [8:0]  cfg_palette = PALETTE_RESET;
   logic [10:0] cfg_width   = WIDTH_RESET;
   logic [10:0] cfg_height  = HEIGHT_RESET;
   logic [11:0] cfg_pitch   = PITCH_RESET;
   logic [7:0]  lut [TABLE_DEPTH];
   int          row_byte = 0;
   int          rows_done = 0;

   pixel_exp_type pixel_q [$];
   pixel_exp_type want;
   int          error_count = 0;
   int          item_count = 0;
   int          pixel_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   indexed_pixel_unpack_remap dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 8);
   end

   function automatic int depth_of(input int entries);
      if (entries > 16) return 8;
      if (entries > 4) return 4;
      if (entries > 2) return 2;
      return 1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at pixel %0d: %s", pixel_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %02h", rsp_tdata));
         end else begin
            want = pixel_q.pop_front();
            if (rsp_tdata !== want.pixel)
               report_mismatch($sformatf("pixel %02h, expected %02h", rsp_tdata, want.pixel));
            if (rsp_tuser !== want.row_end)
               report_mismatch($sformatf("row_end %b, expected %b", rsp_tuser, want.row_end));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_tlast, want.last));
         end
         pixel_count++;
      end
   end

   task automatic unpack_item(input logic [1:0] f, input logic [7:0] ix, input logic [7:0] cl,
                              input logic [7:0] db);
      int bpp, ppb, wid, pit, col;
      int sel;
      bit final_row;
      pixel_exp_type p;
      case (f)
         FUNC_BEGIN: begin
            foreach (lut[i]) lut[i] = 8'h00;
            row_byte  = 0;
            rows_done = 0;
         end
         FUNC_ENTRY: lut[ix] = cl;
         FUNC_PIXEL: begin
            if (rows_done < int'(cfg_height)) begin
               bpp = depth_of(int'(cfg_palette));
               ppb = 8 / bpp;
               wid = (int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
               pit = (cfg_pitch == 0) ? 1 : int'(cfg_pitch);
               final_row = (rows_done + 1) == int'(cfg_height);
               for (int k = 0; k < ppb; k++) begin
                  col = row_byte * ppb + k;
                  if (col < wid) begin
                     sel = (int'(db) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                     p.pixel   = lut[sel];
                     p.row_end = (col + 1) == wid;
                     p.last    = p.row_end && final_row;
                     pixel_q.push_back(p);
                  end
               end
               row_byte++;
               if (row_byte >= pit) begin
                  row_byte = 0;
                  rows_done++;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] f, input logic [7:0] ix, input logic [7:0] cl,
                            input logic [7:0] db);
      if (!no_idle && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {db, cl, ix};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      unpack_item(f, ix, cl, db);
      item_count++;
   endtask

   task automatic send_pixel(input logic [7:0] db);
      send_item(FUNC_PIXEL, 8'($urandom), 8'($urandom), db);
   endtask

   task automatic send_begin();
      send_item(FUNC_BEGIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_entry(input logic [7:0] ix, input logic [7:0] cl);
      send_item(FUNC_ENTRY, ix, cl, 8'($urandom));
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 12'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PALETTE_ENTRIES: cfg_palette = 9'(value);
         CSR_IMAGE_WIDTH:     cfg_width   = 11'(value);
         CSR_IMAGE_HEIGHT:    cfg_height  = 11'(value);
         default:             cfg_pitch   = 12'(value);
      endcase
   endtask

   task automatic set_config(input int pal, input int w, input int h, input int p);
      drain_pipeline();
      write_reg(CSR_PALETTE_ENTRIES, pal);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_ROW_PITCH, p);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_entry(8'hFF, 8'($urandom));
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_item(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'($urandom));
   endtask

   task automatic test_bit_depths();
      int pal_list [4] = '{0, 3, 5, 511};
      int bpp, need;
      foreach (pal_list[i]) begin
         bpp  = depth_of(pal_list[i]);
         need = (4 + 8 / bpp - 1) / (8 / bpp);
         set_config(pal_list[i], 4, 1, need);
         send_begin();
         send_entry(8'((1 << bpp) - 1), 8'($urandom));
         send_entry(8'h00, 8'($urandom));
         for (int b = 0; b < need; b++) send_pixel(8'($urandom));
      end
   endtask

   task automatic test_corner_geometry();
      set_config(256, 0, 2, 1);
      send_begin();
      send_pixel(8'h00);
      send_pixel(8'h01);
      set_config(256, 2, 0, 2);
      send_pixel(8'h02);
      set_config(256, 1, 2, 0);
      send_begin();
      send_entry(8'h5A, 8'hC3);
      send_pixel(8'h5A);
      send_pixel(8'h5A);
      send_pixel(8'h5A);
      set_config(256, 8, 1, 3);
      send_begin();
      send_entry(8'h80, 8'hFF);
      for (int b = 0; b < 3; b++) send_pixel(8'h80);
      send_item(FUNC_UNUSED, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_width_clamp();
      set_config(1, 2047, 2047, 4095);
      send_begin();
      send_entry(8'h01, 8'hFF);
      for (int b = 0; b < 130; b++) send_pixel(8'($urandom));
   endtask

   task automatic test_random_images();
      int pal, w, h, p, bpp, ppb, need, nbytes, nent, phase;
      phase = 0;
      while (item_count < ITEM_TARGET) begin
         no_idle = (phase >= 4 && phase < 8);
         case ($urandom_range(7))
            0: pal = 0;
            1: pal = $urandom_range(1, 2);
            2: pal = $urandom_range(3, 4);
            3: pal = $urandom_range(5, 16);
            4: pal = $urandom_range(17, 256);
            5: pal = $urandom_range(257, 511);
            default: pal = $urandom_range(1, 256);
         endcase
         bpp = depth_of(pal);
         ppb = 8 / bpp;
         w = ($urandom_range(15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 24);
         h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
         need = (w + ppb - 1) / ppb;
         if (w == 0)
            p = $urandom_range(0, 3);
         else if (need > 1 && $urandom_range(7) == 0)
            p = $urandom_range(0, need - 1);
         else
            p = need + $urandom_range(0, 2);
         set_config(pal, w, h, p);
         if ($urandom_range(5) != 0) send_begin();
         nent = $urandom_range(0, (1 << bpp) > 12 ? 12 : (1 << bpp));
         for (int e = 0; e < nent; e++) begin
            if ($urandom_range(3) == 0)
               send_entry(8'($urandom), 8'($urandom));
            else
               send_entry(8'($urandom_range(0, (1 << bpp) - 1)), 8'($urandom));
         end
         nbytes = ((h == 0) ? 2 : h * ((p == 0) ? 1 : p)) + $urandom_range(0, 2);
         for (int b = 0; b < nbytes; b++) begin
            case ($urandom_range(59))
               0, 1, 2: send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
               3, 4:    send_entry(8'($urandom_range(0, (1 << bpp) - 1)), 8'($urandom));
               5:       send_begin();
               default: ;
            endcase
            send_pixel(8'($urandom));
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      foreach (lut[i]) lut[i] = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_bit_depths();
      test_corner_geometry();
      test_width_clamp();
      test_random_images();
      drain_pipeline();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
